@@ hdl/rtic_pkg.sv @@
// ----------------------------------------------------------------------------
// rtic_pkg
// Shared types, constants and helpers for the radix integer to ASCII core.
// ----------------------------------------------------------------------------
package rtic_pkg;

    localparam int VALUE_BITS      = 64;
    localparam int MAX_DIGITS      = VALUE_BITS;
    localparam int DIGIT_ADDR_BITS = $clog2(MAX_DIGITS);
    localparam int RADIX_BITS      = 6;
    localparam int CHAR_BITS       = 7;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = RADIX_BITS;

    // divider retires STEP_BITS dividend bits per cycle
    localparam int STEP_BITS    = 8;
    localparam int DIV_CYCLES   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_PAD_BITS = DIV_CYCLES * STEP_BITS;
    localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UPPER = 1'b1;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

    localparam logic [RADIX_BITS-1:0] DIGIT_NINE = 6'd9;
    localparam logic [RADIX_BITS-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;

    // one conversion job as it sits in the queue
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
        logic                  upper;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(
        input logic [RADIX_BITS-1:0] d,
        input logic                  upper
    );
        logic [CHAR_BITS-1:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d > DIGIT_NINE) begin
            return CHAR_BITS'(d - DIGIT_TEN) + base;
        end
        return CHAR_BITS'(d) + CHAR_ZERO;
    endfunction

endpackage

@@ hdl/rtic_ram.sv @@
// ----------------------------------------------------------------------------
// rtic_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rtic_front.sv @@
// ----------------------------------------------------------------------------
// rtic_front
// Configuration registers and input side: masks the value, clamps the radix
// and packs a job for the queue.
// ----------------------------------------------------------------------------
module rtic_front
    import rtic_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  logic [63:0]               i_value,
    input  t_queue_status             i_q_status,
    output logic                      o_in_stall,
    output logic                      o_push,
    output t_job                      o_job
);

    logic [RADIX_BITS-1:0] r_radix;
    logic                  r_upper;
    logic [RADIX_BITS-1:0] radix_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_upper <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIX: r_radix <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = r_radix;
        end
    end

    assign o_in_stall  = i_q_status.full;
    assign o_push      = i_in_valid && !i_q_status.full;
    assign o_job.value = i_value[VALUE_BITS-1:0];
    assign o_job.radix = radix_eff;
    assign o_job.upper = r_upper;

endmodule

@@ hdl/rtic_queue.sv @@
// ----------------------------------------------------------------------------
// rtic_queue
// Short job FIFO between front and back.
// ----------------------------------------------------------------------------
module rtic_queue
    import rtic_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_job,
    output t_queue_status o_status
);

    t_job                      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

@@ hdl/rtic_div.sv @@
// ----------------------------------------------------------------------------
// rtic_div
// Iterative restoring divider: value by radix, STEP_BITS quotient bits a cycle.
// ----------------------------------------------------------------------------
module rtic_div
    import rtic_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [RADIX_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [RADIX_BITS-1:0] o_remainder
);

    logic [DIV_PAD_BITS-1:0] r_work;
    logic [RADIX_BITS-1:0]   r_rem;
    logic [RADIX_BITS-1:0]   r_divisor;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [DIV_PAD_BITS-1:0] n_work;
    logic [RADIX_BITS-1:0]   n_rem;

    // STEP_BITS compare/subtract steps on the narrow remainder
    always_comb begin
        logic [RADIX_BITS:0]  t;
        logic [STEP_BITS-1:0] q;
        logic [RADIX_BITS-1:0] rem;
        rem = r_rem;
        q   = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            t = {rem, r_work[DIV_PAD_BITS-1-i]};
            if (t >= {1'b0, r_divisor}) begin
                q[STEP_BITS-1-i] = 1'b1;
                rem = RADIX_BITS'(t - {1'b0, r_divisor});
            end else begin
                rem = t[RADIX_BITS-1:0];
            end
        end
        n_rem  = rem;
        n_work = (r_work << STEP_BITS) | DIV_PAD_BITS'(q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= DIV_PAD_BITS'(i_dividend);
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work[VALUE_BITS-1:0];
    assign o_remainder = r_rem;

endmodule

@@ hdl/rtic_back.sv @@
// ----------------------------------------------------------------------------
// rtic_back
// Conversion sequencer: divides repeatedly, stacks digits, then pops them
// most significant first into the output register.
// ----------------------------------------------------------------------------
module rtic_back
    import rtic_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_job                 i_job,
    input  t_queue_status        i_q_status,
    output logic                 o_pop,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [CHAR_BITS-1:0] o_digit_char,
    output logic                 o_last_digit
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_LOAD
    } t_state;

    t_state                   r_state,  n_state;
    logic [DIGIT_ADDR_BITS-1:0] r_cnt,  n_cnt;
    logic [RADIX_BITS-1:0]    r_radix,  n_radix;
    logic                     r_upper,  n_upper;
    logic                     r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]     r_out_char,  n_out_char;
    logic                     r_out_last,  n_out_last;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [RADIX_BITS-1:0] div_divisor;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quot;
    logic [RADIX_BITS-1:0] div_rem;
    logic                  ram_we;
    logic [RADIX_BITS-1:0] ram_rdata;
    logic                  out_free;

    rtic_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    rtic_ram #(
        .WIDTH (RADIX_BITS),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (div_rem),
        .i_raddr (r_cnt),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_radix      = r_radix;
        n_upper      = r_upper;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = i_job.value;
        div_divisor  = i_job.radix;
        ram_we       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop     = 1'b1;
                    div_start = 1'b1;
                    n_radix   = i_job.radix;
                    n_upper   = i_job.upper;
                    n_cnt     = '0;
                    n_state   = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                div_dividend = div_quot;
                div_divisor  = r_radix;
                if (div_done) begin
                    ram_we = 1'b1;
                    // stop on a zero quotient or a full digit stack
                    if (div_quot == '0 ||
                        r_cnt == DIGIT_ADDR_BITS'(MAX_DIGITS - 1)) begin
                        n_state = S_READ;
                    end else begin
                        div_start = 1'b1;
                        n_cnt     = r_cnt + 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = digit_to_ascii(ram_rdata, r_upper);
                    n_out_last  = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_radix    <= n_radix;
        r_upper    <= n_upper;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

endmodule

@@ hdl/radix_integer_to_ascii_core.sv @@
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core
// Converts an unsigned value into ASCII digits in a programmable radix.
// ----------------------------------------------------------------------------
// Each accepted value is emitted as a run of ASCII digits in the configured
// radix (2..36, register values outside that range clamp to the nearest end),
// most significant digit first, no leading zeros, zero giving a single '0'.
// o_last_digit marks the final character of a run. Letters follow the
// upper_case register. The value is divided out one digit at a time by an
// iterative divider that retires 8 dividend bits a cycle, each remainder
// going onto the digit stack RAM; the digits are then popped from the
// stack, and the next job is taken from the queue. An output stall while a
// character waits holds back the next character. A two-entry job queue lets
// up to two further values transfer in while a run is under way, and the
// output register holds a character while the next job starts.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_core
    import rtic_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration: index 0 radix, index 1 upper_case
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // value channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [63:0]               i_value,
    // character channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [6:0]                o_digit_char,
    output logic                      o_last_digit
);

    t_job          front_job;
    t_job          queue_job;
    t_queue_status q_status;
    logic          push;
    logic          pop;

    // front: config registers, radix clamp, value masking
    rtic_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_value     (i_value),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_job       (front_job)
    );

    // the job carries its own radix and case, so a run never sees a later write
    rtic_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (queue_job),
        .o_status (q_status)
    );

    // back: divide loop, digit stack, output register
    rtic_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (queue_job),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radix_integer_to_ascii_core.
// ----------------------------------------------------------------------------
// Values go in on the value channel and ASCII digit runs are checked on the
// character channel. The bench keeps its own copy of the radix and case
// registers and converts each accepted value itself, unless a directed row
// gives the expected text. The characters it predicts are queued and matched
// in order against every output transfer. A short directed table covers reset
// defaults, field extremes, both letter cases and radix clamping at both ends.
// Random phases follow, each with fresh register settings. Both sides idle in
// random bursts, except in quiet phases and in the final phase.
// ----------------------------------------------------------------------------
module tb;
    import rtic_pkg::*;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_RADIX;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [63:0]               i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [6:0]                o_digit_char;
    logic                      o_last_digit;

    radix_integer_to_ascii_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // 8 time unit period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one predicted output character
    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
    } t_char;

    // one row of the directed table; load means drain and reprogram first
    typedef struct {
        bit                    load;
        logic [RADIX_BITS-1:0] radix;
        logic                  upper;
        logic [63:0]           value;
    } t_row;

    localparam int NUM_ROWS = 24;

    t_char owed_chars [$];                 // characters still to come, oldest first

    // bench copy of the configuration registers
    logic [RADIX_BITS-1:0] radix_reg = RADIX_RESET;
    logic                  upper_reg = 1'b0;

    bit quiet = 1'b0;                      // phase without idling
    bit calm  = 1'b0;                      // final stretch, no idling at all
    int errors        = 0;
    int values_sent   = 0;
    int chars_checked = 0;
    int settings_used = 0;
    int stall_left    = 0;

    // Directed rows. An empty text means the predictor supplies the run.
    t_row plan [NUM_ROWS] = '{
        '{1'b0, 6'd2,  1'b0, 64'd0},                  // reset config, zero value
        '{1'b0, 6'd2,  1'b0, 64'd5},
        '{1'b0, 6'd2,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF}, // longest run
        '{1'b0, 6'd2,  1'b0, 64'h8000_0000_0000_0000},
        '{1'b1, 6'd10, 1'b0, 64'd0},
        '{1'b0, 6'd10, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b0, 6'd10, 1'b0, 64'd9},
        '{1'b0, 6'd10, 1'b0, 64'd10},
        '{1'b1, 6'd16, 1'b0, 64'hFF},
        '{1'b0, 6'd16, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b0, 6'd16, 1'b0, 64'h0123_4567_89AB_CDEF},
        '{1'b1, 6'd16, 1'b1, 64'hFF},
        '{1'b0, 6'd16, 1'b1, 64'hDEAD_BEEF},
        '{1'b1, 6'd36, 1'b0, 64'd35},
        '{1'b0, 6'd36, 1'b0, 64'd36},
        '{1'b0, 6'd36, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b1, 6'd36, 1'b1, 64'd35},
        '{1'b1, 6'd0,  1'b0, 64'd2},                  // radix below range
        '{1'b1, 6'd1,  1'b0, 64'd3},
        '{1'b1, 6'd37, 1'b1, 64'd36},                 // radix above range
        '{1'b1, 6'd63, 1'b1, 64'd71},
        '{1'b1, 6'd3,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
        '{1'b1, 6'd35, 1'b0, 64'd34},
        '{1'b0, 6'd35, 1'b0, 64'd0}
    };

    string plan_text [NUM_ROWS] = '{
        "0", "101", "", "",
        "0", "18446744073709551615", "9", "10",
        "ff", "ffffffffffffffff", "123456789abcdef",
        "FF", "DEADBEEF",
        "z", "10", "",
        "Z",
        "10", "11", "10", "1Z",
        "", "y", "0"
    };

    // Convert a value with the current register copies and queue its characters.
    function automatic void predict_digits(input logic [63:0] v);
        logic [63:0]           rest;
        logic [63:0]           base;
        logic [RADIX_BITS-1:0] dig [MAX_DIGITS];
        logic [CHAR_BITS-1:0]  letter_a;
        t_char                 c;
        int                    n;
        int                    k;
        rest = v;
        if (radix_reg < RADIX_MIN)
            base = 64'(RADIX_MIN);
        else if (radix_reg > RADIX_MAX)
            base = 64'(RADIX_MAX);
        else
            base = 64'(radix_reg);
        letter_a = upper_reg ? CHAR_UPPER_A : CHAR_LOWER_A;
        n = 0;
        // least significant digit first; zero still yields one digit
        do begin
            dig[n] = RADIX_BITS'(rest % base);
            rest   = rest / base;
            n++;
        end while (rest != 64'd0 && n < MAX_DIGITS);
        for (k = n - 1; k >= 0; k--) begin
            if (dig[k] > DIGIT_NINE)
                c.ch = CHAR_BITS'(dig[k] - DIGIT_TEN) + letter_a;
            else
                c.ch = CHAR_BITS'(dig[k]) + CHAR_ZERO;
            c.last = (k == 0);
            owed_chars.push_back(c);
        end
    endfunction

    // Mostly narrow values so runs stay short; some full width and one-hot.
    function automatic logic [63:0] random_value();
        logic [63:0] full;
        int          sel;
        int          width;
        full = {$urandom, $urandom};
        sel  = $urandom_range(0, 9);
        case (sel)
            0, 1: return full;
            2:    return 64'd1 << $urandom_range(0, 63);
            3:    return 64'($urandom_range(0, 40));
            default: begin
                width = $urandom_range(1, 24);
                return full & ((64'd1 << width) - 64'd1);
            end
        endcase
    endfunction

    // Offer one value, wait for its transfer, then queue what it should produce.
    // A typed run, when given, replaces the predictor.
    task automatic send_value(input logic [63:0] v, input string typed);
        int    gap;
        int    i;
        t_char c;
        @(negedge i_clk);
        if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_value    = v;
        do @(posedge i_clk); while (o_in_stall);
        if (typed.len() != 0) begin
            for (i = 0; i < typed.len(); i++) begin
                c.ch   = CHAR_BITS'(typed[i]);
                c.last = (i == typed.len() - 1);
                owed_chars.push_back(c);
            end
        end else begin
            predict_digits(v);
        end
        values_sent++;
    endtask

    // Let every owed character come out, then program both registers.
    task automatic write_settings(input logic [RADIX_BITS-1:0] radix,
                                  input logic up);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (owed_chars.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_RADIX;
        i_cfg_data  = radix;
        @(negedge i_clk);
        i_cfg_index = CFG_UPPER;
        i_cfg_data  = {5'($urandom_range(0, 31)), up};   // only bit 0 counts
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        radix_reg = radix;
        upper_reg = up;
        settings_used++;
    endtask

    // Receiver: stalls the output in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0 && !calm) begin
            stall_left  = stall_left - 1;
            i_out_stall = 1'b1;
        end else if (i_rst_n && !quiet && !calm && $urandom_range(0, 15) == 0) begin
            stall_left  = $urandom_range(0, 14);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Output checker: each transfer against the oldest owed character.
    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got char 0x%02h last %0b",
                         $time, o_digit_char, o_last_digit);
                errors++;
            end else begin
                want = owed_chars.pop_front();
                if (o_digit_char !== want.ch) begin
                    $display("%0t: digit_char mismatch: expected 0x%02h, got 0x%02h",
                             $time, want.ch, o_digit_char);
                    errors++;
                end
                if (o_last_digit !== want.last) begin
                    $display("%0t: last_digit mismatch: expected %0b, got %0b",
                             $time, want.last, o_last_digit);
                    errors++;
                end
                chars_checked++;
            end
        end
    end

    initial begin
        int                    r;
        int                    phase_len;
        int                    random_sent;
        int                    sel;
        logic [RADIX_BITS-1:0] radix;

        // synchronous reset, held at the start
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (r = 0; r < NUM_ROWS; r++) begin
            if (plan[r].load)
                write_settings(plan[r].radix, plan[r].upper);
            send_value(plan[r].value, plan_text[r]);
        end

        // random phases; each boundary drains the block before reprogramming
        random_sent = 0;
        while (random_sent < 126) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       radix = RADIX_MIN;
                1:       radix = RADIX_MAX;
                2:       radix = RADIX_BITS'($urandom_range(0, 63));   // may clamp
                default: radix = RADIX_BITS'($urandom_range(2, 36));
            endcase
            write_settings(radix, 1'($urandom_range(0, 1)));
            if (random_sent >= 106) begin
                calm      = 1'b1;       // last stretch runs flat out
                phase_len = 126 - random_sent;
            end else begin
                quiet     = ($urandom_range(0, 3) == 0);
                phase_len = $urandom_range(8, 25);
                if (random_sent + phase_len > 106)
                    phase_len = 106 - random_sent;
            end
            repeat (phase_len) send_value(random_value(), "");
            random_sent += phase_len;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (owed_chars.size() != 0) @(posedge i_clk);
        // catch any stray characters after the last run
        repeat (100) @(posedge i_clk);

        $display("Converted %0d values over %0d register settings, %0d characters checked.",
                 values_sent, settings_used, chars_checked);
        $display("Radix range 2..36 with clamping at both ends, both letter cases.");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog, ends the simulation if it hangs
    initial begin
        #12_000_000;
        $display("%0t: timeout, %0d characters still owed", $time, owed_chars.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
